FILE: hdl/spe_pkg.sv
// Shared constants and types for the strided prime enumerator.
// No dependencies; imported by spe_div and strided_prime_enumerator.
package spe_pkg;

  localparam int VALUE_BITS = 20;
  localparam int NEXT_BITS  = VALUE_BITS + 1;
  localparam int SQ_BITS    = VALUE_BITS + 2;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);
  localparam int IN_W       = 8;
  localparam int OUT_RAW_W  = 2 * VALUE_BITS + 2;
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 4;

  // register indexes
  localparam logic [1:0] REG_FIRST  = 2'd0;
  localparam logic [1:0] REG_STRIDE = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

FILE: hdl/spe_div.sv
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on spe_pkg for widths and the status struct.
module spe_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [spe_pkg::VALUE_BITS-1:0] dividend,
  input  logic [spe_pkg::VALUE_BITS-1:0] divisor,
  output spe_pkg::div_status_t           status
);
  import spe_pkg::*;

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] shreg;
  logic [VALUE_BITS-1:0] dsr;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   rem_next;

  assign trial    = {rem, shreg[VALUE_BITS-1]};
  assign rem_next = (trial >= {1'b0, dsr}) ? trial - {1'b0, dsr} : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      status.done     <= 1'b0;
      status.rem_zero <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_BITS'(VALUE_BITS - 1);
        rem   <= '0;
        shreg <= dividend;
        dsr   <= divisor;
      end else if (busy) begin
        rem   <= rem_next[VALUE_BITS-1:0];
        shreg <= shreg << 1;
        if (cnt == '0) begin
          busy            <= 1'b0;
          status.done     <= 1'b1;
          status.rem_zero <= (rem_next == '0);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/strided_prime_enumerator.sv
// Strided trial-division prime enumerator, top level.
// Path from the accepting edge to m_tvalid: an exhausted step or a candidate
// below 2 goes straight to ST_FINISH; otherwise k trial divisors are run
// (floor(sqrt(n)) - 1 for a prime), each one bound check plus a run on
// the shared remainder unit (spe_div): 20 bit steps and its done flag.
// One request at a time: s_tready is high only while idle; a stalled result holds it low.
// Reset (rst, synchronous): registers to first 0, stride 1, limit all-ones.
module strided_prime_enumerator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [spe_pkg::IN_W-1:0]      s_tdata,  // [0] restart
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [spe_pkg::OUT_W-1:0]     m_tdata,  // candidate, is_prime, prime_count, exhausted
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spe_pkg::APB_AW-1:0]    paddr,
  input  logic [spe_pkg::APB_DW-1:0]    pwdata,
  output logic [spe_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import spe_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;

  logic [2:0]            state;
  logic [VALUE_BITS-1:0] first_cand;
  logic [VALUE_BITS-1:0] stride;
  logic [VALUE_BITS-1:0] limit;
  logic [NEXT_BITS-1:0]  next_value;
  logic [VALUE_BITS-1:0] found_count;
  logic [VALUE_BITS-1:0] count_next;
  logic [NEXT_BITS-1:0]  cand;
  logic [NEXT_BITS-1:0]  cur;
  logic                  exh;
  logic                  prime;
  logic [VALUE_BITS-1:0] dvsr;
  logic [SQ_BITS-1:0]    sq;
  logic                  div_start;
  div_status_t           div_stat;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [VALUE_BITS-1:0] out_cand;
  logic                  out_prime;
  logic [VALUE_BITS-1:0] out_count;
  logic                  out_exh;
  logic                  cfg_we;

  assign pready   = 1'b1;
  assign cfg_we   = psel & penable & pwrite;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign out_load = (state == ST_FINISH) && out_free;
  assign cur      = s_tdata[0] ? {1'b0, first_cand} : next_value;
  assign div_start = (state == ST_CHECK) && (sq <= SQ_BITS'(cand));
  assign count_next = (prime && (found_count != '1)) ? found_count + 1'b1 : found_count;
  assign m_tdata  = OUT_W'({out_exh, out_count, out_prime, out_cand});

  always_comb begin
    case (paddr[3:2])
      REG_FIRST:  prdata = APB_DW'(first_cand);
      REG_STRIDE: prdata = APB_DW'(stride);
      REG_LIMIT:  prdata = APB_DW'(limit);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_cand <= '0;
      stride     <= VALUE_BITS'(1);
      limit      <= '1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_FIRST:  first_cand <= pwdata[VALUE_BITS-1:0];
        REG_STRIDE: stride     <= pwdata[VALUE_BITS-1:0];
        REG_LIMIT:  limit      <= pwdata[VALUE_BITS-1:0];
        default:    ;
      endcase
    end
  end

  spe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cand[VALUE_BITS-1:0]),
    .divisor  (dvsr),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      next_value  <= '0;
      found_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cand       <= cur;
            next_value <= cur;
            if (s_tdata[0]) found_count <= '0;
            exh   <= (cur >= {1'b0, limit});
            prime <= 1'b0;
            dvsr  <= VALUE_BITS'(2);
            sq    <= SQ_BITS'(4);
            // exhausted or below 2: no trial needed
            if ((cur >= {1'b0, limit}) || (cur < NEXT_BITS'(2))) state <= ST_FINISH;
            else state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!div_start) begin
            prime <= 1'b1;
            state <= ST_FINISH;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            if (div_stat.rem_zero) begin
              state <= ST_FINISH;
            end else begin
              // (d+1)^2 = d^2 + 2d + 1
              sq    <= sq + SQ_BITS'({dvsr, 1'b1});
              dvsr  <= dvsr + 1'b1;
              state <= ST_CHECK;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_cand  <= exh ? '0 : cand[VALUE_BITS-1:0];
            out_prime <= prime;
            out_count <= count_next;
            out_exh   <= exh;
            found_count <= count_next;
            if (!exh) next_value <= cand + NEXT_BITS'(stride);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
